>>> hw/rtl/swrms_pkg.sv
`default_nettype none

package swrms_pkg;

  // default build parameters
  localparam int MAX_WINDOW_DEF  = 4096;
  localparam int SAMPLE_BITS_DEF = 16;

  // configuration register indexes
  localparam int CFG_INDEX_BITS = 8;
  localparam int CFG_DATA_BITS  = 17;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_LENGTH     = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_RECIPROCAL = 8'd1;

  // register reset values
  localparam logic [12:0] WINDOW_LENGTH_RST     = 13'd512;
  localparam logic [16:0] WINDOW_RECIPROCAL_RST = 17'd128;

  // fixed-point limits
  localparam logic [16:0] RECIP_ONE = 17'd65536;
  localparam int          ENTRY_W   = 31;
  localparam int          SUM_W     = 32;
  localparam int          LEVEL_W   = 16;
  localparam logic [LEVEL_W-1:0] LEVEL_TOP = 16'd32768;

  // status of the iterative root unit
  typedef struct packed {
    logic busy;
    logic done;
  } root_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/swrms_sqrt.sv
`default_nettype none

module swrms_sqrt (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [swrms_pkg::SUM_W-1:0]  value,
  output swrms_pkg::root_stat_t             stat,
  output logic [swrms_pkg::LEVEL_W-1:0]     root
);
  import swrms_pkg::*;

  logic [SUM_W-1:0] rem_r, rem_nxt;
  logic [SUM_W-1:0] res_r, res_nxt;
  logic [SUM_W-1:0] bit_r, bit_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [SUM_W:0]   trial;

  // one bit pair of the restoring square root per cycle
  always_comb begin
    trial    = {1'b0, res_r} + {1'b0, bit_r};
    rem_nxt  = rem_r;
    res_nxt  = res_r;
    bit_nxt  = bit_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = value;
      res_nxt  = '0;
      bit_nxt  = SUM_W'(1) << (SUM_W - 2);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if ({1'b0, rem_r} >= trial) begin
        rem_nxt = rem_r - trial[SUM_W-1:0];
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      if (bit_r[1:0] != 2'b00) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign root      = res_r[LEVEL_W-1:0];

endmodule

`default_nettype wire

>>> hw/rtl/sliding_window_rms.sv
`default_nettype none

// Moving-window RMS detector. Each signed sample word on in_ is squared,
// scaled by window_reciprocal (Q1.16) and kept in a ring of window_length
// entries; a running sum drops the entry being overwritten and gains the new
// one, and out_ returns floor(sqrt(sum)) as unsigned Q1.15, saturated at
// 32768. An accepted word goes through ring read, square, reciprocal scale,
// subtract and saturating add, then 16 steps of the bit-serial square root
// unit, which sets the rate unless out_tready holds the result. in_tready
// stays low while a word is being worked on. A write to window_length clears
// the window at once (no clearing pass): ring entries not yet written since
// the clear read as zero.
module sliding_window_rms #(
  parameter int MAX_WINDOW  = swrms_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = swrms_pkg::SAMPLE_BITS_DEF,
  localparam int IN_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // in_tdata: [SAMPLE_BITS-1:0] sample
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  input  wire logic [IN_W-1:0]                      in_tdata,
  // out_tdata: [15:0] rms_level
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  output logic [swrms_pkg::LEVEL_W-1:0]             out_tdata,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [swrms_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [swrms_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import swrms_pkg::*;

  localparam int PTR_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int LEN_W  = PTR_W + 1;
  localparam int SQ_W   = 2 * SAMPLE_BITS;
  localparam int PROD_W = SQ_W + 17;
  localparam int SHIFT  = 2 * SAMPLE_BITS - 16;

  typedef enum logic [2:0] {
    S_IDLE, S_SQUARE, S_SCALE, S_SUB, S_ADD, S_ROOT, S_DONE
  } state_t;

  state_t                  state_r;
  logic [12:0]             wlen_r;
  logic [16:0]             recip_r;
  logic [PTR_W-1:0]        ptr_r;
  logic                    wrapped_r;
  logic [SUM_W-1:0]        sum_r;
  logic [SAMPLE_BITS-1:0]  sample_r;
  logic [ENTRY_W-1:0]      rd_data_r;
  logic [SQ_W-1:0]         sq_r;
  logic [PROD_W-1:0]       prod_r;
  logic                    out_valid_r;
  logic [LEVEL_W-1:0]      out_data_r;

  logic [ENTRY_W-1:0]      ring [MAX_WINDOW];

  logic [LEN_W-1:0]        eff_len;
  logic [16:0]             eff_recip;
  logic [SAMPLE_BITS-1:0]  mag;
  logic [ENTRY_W-1:0]      entry;
  logic [ENTRY_W-1:0]      oldest;
  logic [SUM_W:0]          add_sum;
  logic [LEN_W-1:0]        ptr_inc;
  logic                    accept;
  logic                    wlen_wr;
  logic                    root_start;
  root_stat_t              root_stat;
  logic [LEVEL_W-1:0]      root;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign wlen_wr   = cfg_valid && (cfg_index == REG_WINDOW_LENGTH);
  assign root_start = (state_r == S_ADD);

  // effective window length and reciprocal
  always_comb begin
    if (wlen_r == '0) begin
      eff_len = LEN_W'(1);
    end else if (32'(wlen_r) > 32'(MAX_WINDOW)) begin
      eff_len = LEN_W'(MAX_WINDOW);
    end else begin
      eff_len = LEN_W'(wlen_r);
    end
    eff_recip = (recip_r > RECIP_ONE) ? RECIP_ONE : recip_r;
  end

  // datapath helpers
  assign mag     = sample_r[SAMPLE_BITS-1] ? (~sample_r + 1'b1) : sample_r;
  assign entry   = prod_r[SHIFT +: ENTRY_W];
  assign oldest  = wrapped_r ? rd_data_r : '0;
  assign add_sum = {1'b0, sum_r} + {2'b0, entry};
  assign ptr_inc = {1'b0, ptr_r} + 1'b1;

  // ring memory: read at acceptance, write on the add step
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data_r <= ring[ptr_r];
    end
    if (state_r == S_ADD) begin
      ring[ptr_r] <= entry;
    end
  end

  // sequencer, window state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wlen_r      <= WINDOW_LENGTH_RST;
      recip_r     <= WINDOW_RECIPROCAL_RST;
      ptr_r       <= '0;
      wrapped_r   <= 1'b0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // in S_DONE the output register is reloaded below instead
      if (out_valid_r && out_tready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            sample_r <= in_tdata[SAMPLE_BITS-1:0];
            state_r  <= S_SQUARE;
          end
        end
        S_SQUARE: begin
          sq_r    <= SQ_W'(mag) * SQ_W'(mag);
          state_r <= S_SCALE;
        end
        S_SCALE: begin
          prod_r  <= PROD_W'(sq_r) * PROD_W'(eff_recip);
          state_r <= S_SUB;
        end
        S_SUB: begin
          sum_r   <= (sum_r >= SUM_W'(oldest)) ? (sum_r - SUM_W'(oldest)) : '0;
          state_r <= S_ADD;
        end
        S_ADD: begin
          sum_r <= add_sum[SUM_W] ? '1 : add_sum[SUM_W-1:0];
          if (ptr_inc >= eff_len) begin
            ptr_r     <= '0;
            wrapped_r <= 1'b1;
          end else begin
            ptr_r <= ptr_inc[PTR_W-1:0];
          end
          state_r <= S_ROOT;
        end
        S_ROOT: begin
          if (root_stat.done) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= (root > LEVEL_TOP) ? LEVEL_TOP : root;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
      // configuration words
      if (cfg_valid) begin
        case (cfg_index)
          REG_WINDOW_LENGTH:     wlen_r  <= cfg_data[12:0];
          REG_WINDOW_RECIPROCAL: recip_r <= cfg_data;
          default: ;
        endcase
      end
      if (wlen_wr) begin
        ptr_r     <= '0;
        wrapped_r <= 1'b0;
        sum_r     <= '0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  swrms_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (root_start),
    .value (add_sum[SUM_W] ? {SUM_W{1'b1}} : add_sum[SUM_W-1:0]),
    .stat  (root_stat),
    .root  (root)
  );

endmodule

`default_nettype wire

>>> sim/sliding_window_rms_tb.sv
`timescale 1ns / 100ps

module sliding_window_rms_tb;
  import swrms_pkg::*;

  localparam int WIN_TOP       = MAX_WINDOW_DEF;
  localparam int GAP_TOP       = 18;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PRINT_CAP     = 100;
  localparam int RANDOM_WORDS  = 600;

  // register indexes the block does not decode
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNMAPPED     = 8'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNMAPPED_TOP = 8'hFF;

  typedef enum logic [1:0] {WORD_SAMPLE, WORD_CONFIG, WORD_DRAIN} word_kind_t;

  typedef struct {
    word_kind_t                kind;
    logic [15:0]               smp;
    logic [CFG_INDEX_BITS-1:0] idx;
    logic [CFG_DATA_BITS-1:0]  val;
  } stim_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                      in_tvalid = 1'b0;
  logic                      in_tready;
  logic [15:0]               in_tdata = '0;
  logic                      out_tvalid;
  logic                      out_tready = 1'b0;
  logic [LEVEL_W-1:0]        out_tdata;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

  sliding_window_rms uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // words waiting to be driven, expected levels waiting to come back
  stim_word_t         pending_words[$];
  logic [LEVEL_W-1:0] rms_level_q[$];
  int                 mismatch_count = 0;
  int unsigned        cycle_count = 0;

  // shadow of the detector state
  logic [ENTRY_W-1:0] square_shadow [WIN_TOP];
  logic [SUM_W-1:0]   sum_shadow;
  int unsigned        slot_shadow;
  logic [12:0]        win_len_shadow;
  logic [16:0]        win_recip_shadow;

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) begin
      $display("[%0t] %s", $time, what);
    end
  endtask

  task automatic clear_window_shadow();
    for (int i = 0; i < WIN_TOP; i++) begin
      square_shadow[i] = '0;
    end
    sum_shadow  = '0;
    slot_shadow = 0;
  endtask

  task automatic apply_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                input logic [CFG_DATA_BITS-1:0] val);
    if (idx == REG_WINDOW_LENGTH) begin
      win_len_shadow = val[12:0];
      clear_window_shadow();
    end else if (idx == REG_WINDOW_RECIPROCAL) begin
      win_recip_shadow = val;
    end
  endtask

  // advance the window by one sample and queue the level it should give
  task automatic compute_rms_level(input logic [15:0] smp);
    logic [16:0]        mag;
    longint unsigned    prod;
    longint unsigned    acc;
    longint unsigned    root;
    longint unsigned    trial;
    logic [ENTRY_W-1:0] entry;
    logic [ENTRY_W-1:0] oldest;
    int unsigned        len;
    int unsigned        rcp;
    int unsigned        slot;

    len = (win_len_shadow == 0) ? 1 :
          (win_len_shadow > WIN_TOP) ? WIN_TOP : win_len_shadow;
    rcp = (win_recip_shadow > RECIP_ONE) ? RECIP_ONE : win_recip_shadow;
    mag = smp[15] ? (17'h10000 - {1'b0, smp}) : {1'b0, smp};
    prod  = 64'(mag) * 64'(mag) * 64'(rcp);
    entry = ENTRY_W'(prod >> 16);

    slot   = (slot_shadow >= len) ? 0 : slot_shadow;
    oldest = square_shadow[slot];
    // remove floors at zero, add saturates
    sum_shadow = (sum_shadow >= oldest) ? sum_shadow - oldest : '0;
    acc = 64'(sum_shadow) + 64'(entry);
    sum_shadow = (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
    square_shadow[slot] = entry;
    slot++;
    slot_shadow = (slot >= len) ? 0 : slot;

    // floor square root, one bit at a time from the top
    root = 0;
    for (int b = 15; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= 64'(sum_shadow)) root = trial;
    end
    if (root > LEVEL_TOP) root = LEVEL_TOP;
    rms_level_q.push_back(LEVEL_W'(root));
  endtask

  function automatic stim_word_t sample_word(input logic [15:0] smp);
    stim_word_t w;
    w.kind = WORD_SAMPLE;
    w.smp  = smp;
    w.idx  = '0;
    w.val  = '0;
    return w;
  endfunction

  function automatic stim_word_t config_word(input logic [CFG_INDEX_BITS-1:0] idx,
                                             input logic [CFG_DATA_BITS-1:0] val);
    stim_word_t w;
    w.kind = WORD_CONFIG;
    w.smp  = '0;
    w.idx  = idx;
    w.val  = val;
    return w;
  endfunction

  function automatic stim_word_t drain_word();
    stim_word_t w;
    w.kind = WORD_DRAIN;
    w.smp  = '0;
    w.idx  = '0;
    w.val  = '0;
    return w;
  endfunction

  // clock and reset
  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  // timeout
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("sliding_window_rms: mismatch");
      $finish;
    end
  end

  // driver: samples and register writes; register writes and pauses wait for
  // every outstanding level to come back
  int  send_gap = 0;
  bit  send_calm = 1'b0;

  always @(posedge clk) begin : driver
    stim_word_t w;
    logic       nxt_in_valid;
    logic       nxt_cfg_valid;

    if (!rst_n) begin
      in_tvalid <= 1'b0;
      cfg_valid <= 1'b0;
      send_gap = 0;
    end else begin
      nxt_in_valid  = in_tvalid;
      nxt_cfg_valid = cfg_valid;
      if (in_tvalid && in_tready) begin
        compute_rms_level(in_tdata);
        nxt_in_valid = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        apply_register(cfg_index, cfg_data);
        nxt_cfg_valid = 1'b0;
      end
      if (!nxt_in_valid && !nxt_cfg_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_words.size() > 0) begin
          w = pending_words[0];
          case (w.kind)
            WORD_SAMPLE: begin
              void'(pending_words.pop_front());
              in_tdata     <= w.smp;
              nxt_in_valid = 1'b1;
            end
            WORD_CONFIG: begin
              if (rms_level_q.size() == 0) begin
                void'(pending_words.pop_front());
                cfg_index     <= w.idx;
                cfg_data      <= w.val;
                nxt_cfg_valid = 1'b1;
              end
            end
            default: begin
              if (rms_level_q.size() == 0) void'(pending_words.pop_front());
            end
          endcase
          if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
          send_gap = send_calm ? 0 : $urandom_range(0, GAP_TOP);
        end
      end
      in_tvalid <= nxt_in_valid;
      cfg_valid <= nxt_cfg_valid;
    end
  end

  // monitor: check each level, then stall the receiver at random
  int  recv_stall = 0;
  bit  recv_calm = 1'b0;

  always @(posedge clk) begin : monitor
    logic [LEVEL_W-1:0] expected;

    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (rms_level_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected rms_level word %0d", out_tdata));
        end else begin
          expected = rms_level_q.pop_front();
          if (out_tdata !== expected) begin
            flag_mismatch($sformatf("rms_level got %0d expected %0d",
                                    out_tdata, expected));
          end
        end
        if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
        recv_stall = recv_calm ? 0 : $urandom_range(0, GAP_TOP);
      end else if (recv_stall > 0) begin
        recv_stall--;
      end
      out_tready <= (recv_stall == 0);
    end
  end

  // stimulus and end of run
  initial begin : stimulus
    int unsigned        words_left;
    int unsigned        wl;
    int unsigned        eff;
    int unsigned        rc;
    int unsigned        count;
    int unsigned        pick;
    logic [15:0]        smp;

    win_len_shadow   = WINDOW_LENGTH_RST;
    win_recip_shadow = WINDOW_RECIPROCAL_RST;
    clear_window_shadow();

    // reset settings: zero, both full-scale ends, smallest magnitudes
    pending_words.push_back(sample_word(16'h0000));
    pending_words.push_back(sample_word(16'h7FFF));
    pending_words.push_back(sample_word(16'h8000));
    pending_words.push_back(sample_word(16'hFFFF));
    pending_words.push_back(sample_word(16'h0001));

    // one-sample window at unity: level lands exactly on the top value
    pending_words.push_back(config_word(REG_WINDOW_LENGTH, 17'd1));
    pending_words.push_back(config_word(REG_WINDOW_RECIPROCAL, 17'd65536));
    pending_words.push_back(sample_word(16'h8000));
    pending_words.push_back(sample_word(16'h7FFF));

    // two full-scale squares: level saturates
    pending_words.push_back(config_word(REG_WINDOW_LENGTH, 17'd2));
    pending_words.push_back(sample_word(16'h8000));
    pending_words.push_back(sample_word(16'h8000));

    // four full-scale squares overflow the sum, zeros then floor it
    pending_words.push_back(config_word(REG_WINDOW_LENGTH, 17'd4));
    repeat (4) pending_words.push_back(sample_word(16'h8000));
    repeat (4) pending_words.push_back(sample_word(16'h0000));

    // reciprocal above unity, zero window acts as one
    pending_words.push_back(config_word(REG_WINDOW_RECIPROCAL, 17'h1FFFF));
    pending_words.push_back(config_word(REG_WINDOW_LENGTH, 17'd0));
    pending_words.push_back(sample_word(16'h8001));

    // zero reciprocal, then writes to undecoded indexes
    pending_words.push_back(config_word(REG_WINDOW_RECIPROCAL, 17'd0));
    pending_words.push_back(sample_word(16'h7FFF));
    pending_words.push_back(config_word(REG_UNMAPPED, 17'h0AAAA));
    pending_words.push_back(config_word(REG_UNMAPPED_TOP, 17'h1FFFF));
    pending_words.push_back(sample_word(16'h0064));

    // oversized window acts as the largest, then the largest written twice
    pending_words.push_back(config_word(REG_WINDOW_LENGTH, 17'h1FFFF));
    pending_words.push_back(config_word(REG_WINDOW_RECIPROCAL, 17'd1));
    pending_words.push_back(sample_word(16'h5555));
    pending_words.push_back(sample_word(16'hAAAA));
    pending_words.push_back(config_word(REG_WINDOW_LENGTH, 17'd4096));
    pending_words.push_back(config_word(REG_WINDOW_LENGTH, 17'd4096));
    pending_words.push_back(sample_word(16'h7FFF));

    // random phases, mostly short windows so the ring wraps often
    words_left = RANDOM_WORDS;
    while (words_left > 0) begin
      pick = $urandom_range(0, 19);
      if (pick == 0)      wl = 0;
      else if (pick == 1) wl = WIN_TOP;
      else if (pick == 2) wl = $urandom_range(WIN_TOP + 1, 8191);
      else if (pick <= 4) wl = $urandom_range(17, WIN_TOP - 1);
      else                wl = $urandom_range(1, 16);
      eff = (wl == 0) ? 1 : (wl > WIN_TOP) ? WIN_TOP : wl;

      pick = $urandom_range(0, 9);
      if (pick == 0)      rc = $urandom_range(0, 131071);
      else if (pick == 1) rc = RECIP_ONE;
      else if (pick == 2) rc = 0;
      else                rc = RECIP_ONE / eff + $urandom_range(0, 3);

      if ($urandom_range(0, 1)) begin
        pending_words.push_back(config_word(REG_WINDOW_LENGTH, CFG_DATA_BITS'(wl)));
        pending_words.push_back(config_word(REG_WINDOW_RECIPROCAL, CFG_DATA_BITS'(rc)));
      end else begin
        if ($urandom_range(0, 3) != 0) begin
          pending_words.push_back(config_word(REG_WINDOW_RECIPROCAL, CFG_DATA_BITS'(rc)));
        end
        pending_words.push_back(config_word(REG_WINDOW_LENGTH, CFG_DATA_BITS'(wl)));
      end
      if ($urandom_range(0, 7) == 0) begin
        pending_words.push_back(config_word(CFG_INDEX_BITS'($urandom_range(2, 255)),
                                            CFG_DATA_BITS'($urandom)));
      end

      count = (eff <= 16) ? $urandom_range(eff * 2, eff * 3 + 20) : $urandom_range(10, 40);
      if (count > words_left) count = words_left;
      for (int n = 0; n < count; n++) begin
        pick = $urandom_range(0, 9);
        if (pick == 0)      smp = 16'h8000;
        else if (pick == 1) smp = 16'h7FFF;
        else if (pick <= 5) smp = 16'($urandom);
        else begin
          smp = 16'($urandom_range(0, 2047));
          if ($urandom_range(0, 1)) smp = -smp;
        end
        pending_words.push_back(sample_word(smp));
        // pause the sender now and then until the block has drained
        if ($urandom_range(0, 59) == 0) pending_words.push_back(drain_word());
      end
      words_left -= count;
    end

    // wait for everything to be sent and every level to return
    @(posedge clk);
    while (pending_words.size() != 0 || in_tvalid || cfg_valid || rms_level_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("sliding_window_rms: match");
    end else begin
      $display("sliding_window_rms: mismatch");
    end
    $finish;
  end

endmodule
